// ===== rtl/sarg_pkg.sv =====
// Shared types, constants and codes of the stepper ramp generator.
`timescale 1ns / 1ps
`default_nettype none

package sarg_pkg;

  // Timestamp rate and the fixed-point scale between speed and interval
  localparam int unsigned TICKS_PER_SECOND = 1000000;
  localparam logic [47:0] SCALE = 48'(TICKS_PER_SECOND) << 16;

  // Shared divider width and its step counter width
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Format limits
  localparam logic signed [23:0] SPD_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SPD_MIN = 24'sh800000;
  localparam logic signed [39:0] RI_MAX  = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] RI_MIN  = 40'sh80_0000_0000;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST = 1'd1;

  // Item kinds
  typedef enum logic [2:0] {
    K_TICK   = 3'd0,
    K_TARGET = 3'd1,
    K_RUN    = 3'd2,
    K_STOP   = 3'd3,
    K_SETPOS = 3'd4,
    K_SPEED  = 3'd5
  } kind_t;

endpackage

`default_nettype wire

// ===== rtl/sarg_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sarg_div
  import sarg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient
);

  logic [DIV_W:0]     rem_r;
  logic [DIV_W-1:0]   quo_r;
  logic [DIV_W-1:0]   den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [DIV_W:0] shift;
  logic           fits;

  // Shift in the next dividend bit and trial-subtract
  assign shift = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign fits  = shift >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (go) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == DIV_CNT_W'(1));
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (shift - {1'b0, den_r}) : shift;
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/stepper_accel_ramp_generator_unit.sv =====
// Top level of the stepper ramp generator: sequencer, state and stream ports.
//
//  channel  | ports                          | contents
//  ---------+--------------------------------+---------------------------------
//  in       | in_tvalid/in_tready/in_tdata   | tdata: now_us, speed_value,
//           | in_tuser                       |   position_value; tuser: kind
//  out      | out_tvalid/out_tready/out_tdata| step flags, current_position
//  cfg      | cfg_wr_en/cfg_index/cfg_wdata  | acceleration, first_interval
//
// One item at a time; the divisions it needs set how long an item takes.
// Each division runs on the shared divider; a seeking tick that
// starts the ramp-down runs six of them, which sets the worst case.
// Synchronous active-low reset clears all motion state, configuration and control registers.
// A finished result waits in the output register; the next item is taken
// meanwhile and only stalls at its end if the result is still not taken.
`timescale 1ns / 1ps
`default_nettype none

module stepper_accel_ramp_generator_unit
  import sarg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [87:0]          in_tdata,   // now_us, speed_value, position_value
  input  wire logic [2:0]           in_tuser,   // kind
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [39:0]               out_tdata,  // step_pulse, step_forward,
                                                // release_res, running,
                                                // seeking_position,
                                                // current_position, zero pad
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_DIVW, S_SS_IFS, S_ST, S_ST_IFS, S_ST_END,
    S_UA, S_UA_R, S_CNS, S_CNS_RD, S_CNS_SFI, S_CNS_SFR, S_CNS_CMP,
    S_RUN_END, S_SEEK_SDR, S_SEEK_CNS, S_SEEK_END, S_OUT
  } state_t;

  state_t state_r, dret_r, ua_ret_r, cns_ret_r, st_ret_r;

  // Configuration
  logic [19:0] accel_r;
  logic [31:0] first_r;

  // Motion state
  logic signed [23:0] speed_now_r, speed_goal_r;
  logic [31:0]        interval_now_r, interval_goal_r;
  logic signed [39:0] ramp_int_r;
  logic signed [31:0] ramp_idx_r;
  logic [31:0]        last_r, pos_r, goal_r;
  logic               seek_r;

  // Per-item registers
  logic [2:0]         kind_r;
  logic [31:0]        now_r, posin_r;
  logic signed [23:0] spd_r, st_v_r, ns_r;
  logic               dir_r, qneg_r;
  logic               pulse_r, fwd_r, rel_r;

  // Divider interface
  logic             dv_go_r;
  logic [DIV_W-1:0] dv_a_r, dv_b_r;
  logic             dv_done;
  logic [DIV_W-1:0] dv_q;

  // Output register
  logic        out_valid_r;
  logic [39:0] out_data_r;

  sarg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (dv_go_r),
    .dividend (dv_a_r),
    .divisor  (dv_b_r),
    .done     (dv_done),
    .quotient (dv_q)
  );

  // Magnitudes of speed operands
  logic [23:0] st_mag, spd_mag;
  assign st_mag  = st_v_r[23] ? 24'(-st_v_r) : 24'(st_v_r);
  assign spd_mag = spd_r[23] ? 24'(-spd_r) : 24'(spd_r);

  // Stop distance operands
  logic signed [47:0] sq_s;
  logic [DIV_W-1:0]   sd_den;
  assign sq_s   = speed_now_r * speed_now_r;
  assign sd_den = {11'b0, accel_r, 17'b0};

  logic        accel_nz, spd_nz, spd_pos;
  logic [39:0] base40;
  assign accel_nz = accel_r != '0;
  assign spd_nz   = speed_now_r != '0;
  assign spd_pos  = spd_nz && !speed_now_r[23];
  assign base40   = {8'b0, (interval_now_r != '0) ? interval_now_r : first_r};

  // Ramp update operands
  logic               dir_up;
  logic [39:0]        ri_mag;
  logic signed [35:0] ri36, t36, den36;
  logic [35:0]        den_mag;
  assign dir_up  = speed_goal_r >= speed_now_r;
  assign ri_mag  = ramp_int_r[39] ? 40'(-ramp_int_r) : 40'(ramp_int_r);
  assign ri36    = {{4{ramp_idx_r[31]}}, ramp_idx_r};
  assign t36     = dir_up ? ri36 : -ri36;
  assign den36   = (t36 <<< 2) + 36'sd1;
  assign den_mag = den36[35] ? 36'(-den36) : 36'(den36);

  // New ramp interval, saturated to 40 bits
  logic signed [42:0] ri43, q43, qs43, c43;
  logic signed [39:0] c_sat;
  assign ri43  = {{3{ramp_int_r[39]}}, ramp_int_r};
  assign q43   = {1'b0, dv_q[41:0]};
  assign qs43  = qneg_r ? -q43 : q43;
  assign c43   = ri43 - qs43;
  assign c_sat = (c43[42:39] == 4'b0000 || c43[42:39] == 4'b1111) ? c43[39:0]
               : (c43[42] ? RI_MIN : RI_MAX);

  // Speed from ramp interval
  logic signed [23:0] sfi_res;
  always_comb begin
    if (!ramp_int_r[39]) begin
      sfi_res = (|dv_q[47:23]) ? SPD_MAX : $signed(dv_q[23:0]);
    end else if ((|dv_q[47:24]) || (dv_q[23] && (|dv_q[22:0]))) begin
      sfi_res = SPD_MIN;
    end else begin
      sfi_res = -$signed(dv_q[23:0]);
    end
  end

  logic [31:0] q_sat32, ri_sat32;
  assign q_sat32  = (|dv_q[47:32]) ? 32'hFFFF_FFFF : dv_q[31:0];
  assign ri_sat32 = (|ri_mag[39:32]) ? 32'hFFFF_FFFF : ri_mag[31:0];

  // Step timing
  logic [31:0] gap, pos_step;
  logic        step_due;
  assign gap      = now_r - last_r;
  assign step_due = (interval_now_r != '0) && ({gap, 8'b0} >= {8'b0, interval_now_r});
  assign pos_step = pos_r + (spd_pos ? 32'd1 : (spd_nz ? 32'hFFFF_FFFF : 32'd0));

  // Run-to-position direction check
  logic [31:0]        rdelta;
  logic               run_flip;
  logic signed [23:0] neg_goal;
  assign rdelta   = posin_r - pos_r;
  assign run_flip = ((rdelta == '0) != (speed_goal_r == '0)) ||
                    (rdelta[31] != speed_goal_r[23]);
  assign neg_goal = (speed_goal_r == SPD_MIN) ? SPD_MAX : -speed_goal_r;

  // Steps still to go while seeking
  logic [31:0] sdelta, togo;
  assign sdelta = goal_r - pos_r;
  assign togo   = sdelta[31] ? 32'(-sdelta) : sdelta;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      dret_r          <= S_IDLE;
      ua_ret_r        <= S_IDLE;
      cns_ret_r       <= S_IDLE;
      st_ret_r        <= S_IDLE;
      accel_r         <= '0;
      first_r         <= '0;
      speed_now_r     <= '0;
      speed_goal_r    <= '0;
      interval_now_r  <= '0;
      interval_goal_r <= '0;
      ramp_int_r      <= '0;
      ramp_idx_r      <= '0;
      last_r          <= '0;
      pos_r           <= '0;
      goal_r          <= '0;
      seek_r          <= 1'b0;
      dv_go_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ACCEL: accel_r <= cfg_wdata[19:0];
          REG_FIRST: first_r <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop the result once taken, unless a new one replaces it
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r  <= in_tuser;
            now_r   <= in_tdata[31:0];
            spd_r   <= $signed(in_tdata[55:32]);
            posin_r <= in_tdata[87:56];
            pulse_r <= 1'b0;
            fwd_r   <= 1'b0;
            rel_r   <= 1'b0;
            state_r <= S_DEC;
          end
        end

        S_DEC: begin
          case (kind_r)
            K_TICK: begin
              if (step_due) begin
                pos_r   <= pos_step;
                last_r  <= now_r;
                pulse_r <= spd_nz;
                fwd_r   <= spd_pos;
                if (seek_r) begin
                  if (goal_r == pos_step) begin
                    // Target reached: stop at once
                    speed_now_r     <= '0;
                    speed_goal_r    <= '0;
                    interval_now_r  <= '0;
                    interval_goal_r <= '0;
                    if (accel_nz) begin
                      ramp_idx_r <= '0;
                      ramp_int_r <= '0;
                    end
                    last_r  <= '0;
                    rel_r   <= 1'b1;
                    seek_r  <= 1'b0;
                    state_r <= S_OUT;
                  end else if (accel_nz) begin
                    if (speed_goal_r != '0) begin
                      dv_go_r <= 1'b1;
                      dv_a_r  <= DIV_W'(unsigned'(sq_s));
                      dv_b_r  <= sd_den;
                      dret_r  <= S_SEEK_SDR;
                      state_r <= S_DIVW;
                    end else begin
                      cns_ret_r <= S_SEEK_END;
                      state_r   <= S_CNS;
                    end
                  end else begin
                    state_r <= S_SEEK_END;
                  end
                end else begin
                  cns_ret_r <= S_OUT;
                  state_r   <= S_CNS;
                end
              end else begin
                state_r <= S_OUT;
              end
            end
            K_TARGET: begin
              st_v_r   <= spd_r;
              st_ret_r <= S_OUT;
              state_r  <= S_ST;
            end
            K_RUN: begin
              goal_r <= posin_r;
              if (accel_nz && run_flip) begin
                st_v_r   <= neg_goal;
                st_ret_r <= S_RUN_END;
                state_r  <= S_ST;
              end else begin
                state_r <= S_RUN_END;
              end
            end
            K_STOP: begin
              speed_now_r     <= '0;
              speed_goal_r    <= '0;
              interval_now_r  <= '0;
              interval_goal_r <= '0;
              if (accel_nz) begin
                ramp_idx_r <= '0;
                ramp_int_r <= '0;
              end
              last_r  <= '0;
              rel_r   <= 1'b1;
              seek_r  <= 1'b0;
              state_r <= S_OUT;
            end
            K_SETPOS: begin
              goal_r  <= posin_r;
              pos_r   <= posin_r;
              state_r <= S_OUT;
            end
            K_SPEED: begin
              speed_now_r <= spd_r;
              if (spd_r == '0) begin
                interval_now_r <= '0;
                rel_r          <= 1'b1;
                ua_ret_r       <= S_OUT;
                state_r        <= S_UA;
              end else begin
                dv_go_r <= 1'b1;
                dv_a_r  <= SCALE;
                dv_b_r  <= {24'b0, spd_mag};
                dret_r  <= S_SS_IFS;
                state_r <= S_DIVW;
              end
            end
            default: state_r <= S_OUT;
          endcase
        end

        // Wait for the shared divider
        S_DIVW: begin
          dv_go_r <= 1'b0;
          if (dv_done) state_r <= dret_r;
        end

        S_SS_IFS: begin
          interval_now_r <= q_sat32;
          ua_ret_r       <= S_OUT;
          state_r        <= S_UA;
        end

        // Set target speed
        S_ST: begin
          speed_goal_r <= st_v_r;
          ua_ret_r     <= S_CNS;
          cns_ret_r    <= S_ST_END;
          if (st_v_r == '0) begin
            interval_goal_r <= '0;
            state_r         <= S_UA;
          end else begin
            dv_go_r <= 1'b1;
            dv_a_r  <= SCALE;
            dv_b_r  <= {24'b0, st_mag};
            dret_r  <= S_ST_IFS;
            state_r <= S_DIVW;
          end
        end

        S_ST_IFS: begin
          interval_goal_r <= q_sat32;
          state_r         <= S_UA;
        end

        S_ST_END: begin
          last_r  <= '0;
          state_r <= st_ret_r;
        end

        // Re-seed the ramp from the present speed
        S_UA: begin
          if (!accel_nz) begin
            state_r <= ua_ret_r;
          end else if (!spd_nz) begin
            ramp_idx_r <= '0;
            ramp_int_r <= '0;
            state_r    <= ua_ret_r;
          end else begin
            dv_go_r <= 1'b1;
            dv_a_r  <= DIV_W'(unsigned'(sq_s));
            dv_b_r  <= sd_den;
            dret_r  <= S_UA_R;
            state_r <= S_DIVW;
          end
        end

        S_UA_R: begin
          ramp_idx_r <= spd_pos ? $signed(dv_q[31:0]) : -$signed(dv_q[31:0]);
          ramp_int_r <= spd_pos ? $signed(base40) : -$signed(base40);
          state_r    <= ua_ret_r;
        end

        // Advance the ramp by one step
        S_CNS: begin
          dir_r <= dir_up;
          if (!accel_nz || speed_now_r == speed_goal_r) begin
            state_r <= cns_ret_r;
          end else if (speed_goal_r == '0 && ramp_idx_r == '0) begin
            interval_now_r <= interval_goal_r;
            speed_now_r    <= '0;
            rel_r          <= 1'b1;
            state_r        <= cns_ret_r;
          end else if (ramp_idx_r == '0) begin
            ramp_int_r <= dir_up ? $signed({8'b0, first_r}) : -$signed({8'b0, first_r});
            state_r    <= S_CNS_SFI;
          end else begin
            qneg_r  <= ramp_int_r[39] ^ den36[35];
            dv_go_r <= 1'b1;
            dv_a_r  <= {7'b0, ri_mag, 1'b0};
            dv_b_r  <= {12'b0, den_mag};
            dret_r  <= S_CNS_RD;
            state_r <= S_DIVW;
          end
        end

        S_CNS_RD: begin
          ramp_int_r <= c_sat;
          state_r    <= S_CNS_SFI;
        end

        S_CNS_SFI: begin
          if (ramp_int_r == '0) begin
            ns_r    <= SPD_MAX;
            state_r <= S_CNS_CMP;
          end else begin
            dv_go_r <= 1'b1;
            dv_a_r  <= SCALE;
            dv_b_r  <= {8'b0, ri_mag};
            dret_r  <= S_CNS_SFR;
            state_r <= S_DIVW;
          end
        end

        S_CNS_SFR: begin
          ns_r    <= sfi_res;
          state_r <= S_CNS_CMP;
        end

        // Clamp at the target speed or take the ramp value
        S_CNS_CMP: begin
          if ((dir_r && ns_r > speed_goal_r) || (!dir_r && ns_r < speed_goal_r)) begin
            interval_now_r <= interval_goal_r;
            speed_now_r    <= speed_goal_r;
          end else begin
            interval_now_r <= ri_sat32;
            speed_now_r    <= ns_r;
            ramp_idx_r     <= dir_r ? ramp_idx_r + 32'sd1 : ramp_idx_r - 32'sd1;
          end
          state_r <= cns_ret_r;
        end

        S_RUN_END: begin
          if (accel_nz) last_r <= '0;
          seek_r  <= 1'b1;
          state_r <= S_OUT;
        end

        // Begin ramping down once the stop distance exceeds what is left
        S_SEEK_SDR: begin
          if (dv_q > {16'b0, togo}) begin
            st_v_r   <= '0;
            st_ret_r <= S_SEEK_CNS;
            state_r  <= S_ST;
          end else begin
            state_r <= S_SEEK_CNS;
          end
        end

        S_SEEK_CNS: begin
          cns_ret_r <= S_SEEK_END;
          state_r   <= S_CNS;
        end

        S_SEEK_END: begin
          seek_r  <= spd_nz;
          state_r <= S_OUT;
        end

        // Hand the result to the output register
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {3'b0, pos_r, seek_r, spd_nz, rel_r, fwd_r, pulse_r};
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
